### rtl/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// Types and constants shared by the run header parser modules.
// ----------------------------------------------------------------------------
package bbc_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0]  COUNT_MAX = 8'd255;
    localparam logic [15:0] FILL_MAX  = 16'hFFFF;

    // run types
    localparam logic [2:0] RT_NONE      = 3'd0;
    localparam logic [2:0] RT_FILL_TAIL = 3'd1;
    localparam logic [2:0] RT_FILL_ODD  = 3'd2;
    localparam logic [2:0] RT_CNT_TAIL  = 3'd3;
    localparam logic [2:0] RT_CNT_ODD   = 3'd4;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_COUNTER = 2'd1,
        PH_TAIL    = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_RUN  = 2'd0,
        KIND_TAIL = 2'd1,
        KIND_ODD  = 2'd2,
        KIND_BAD  = 2'd3
    } kind_t;

    // one queue entry; pair marks a run record followed by its odd byte
    typedef struct packed {
        logic [1:0]  item_kind;
        logic [2:0]  run_kind;
        logic        fill_value;
        logic [15:0] fill_count;
        logic [3:0]  tail_count;
        logic [7:0]  counter_count;
        logic [2:0]  odd_position;
        logic [7:0]  data_byte;
        logic        run_end;
        logic        pair;
    } entry_t;

endpackage

### rtl/bbc_run_header_parser.sv
// ----------------------------------------------------------------------------
// bbc_run_header_parser
// Byte-aligned bitmap code run decoder: headers in, run records and bytes out.
// ----------------------------------------------------------------------------
// Takes one compressed byte per cycle on the slave side whenever the result
// queue has room, so a steady stream runs at one byte per cycle. The parser
// queues at most one entry per byte; an odd-byte run (types 2 and 4) yields
// two output words from one entry, so the master side gives one word per
// cycle while the receiver takes them; bytes back up while pairs drain or
// the receiver stalls. Results pass through the queue, then the output
// register. A header with its top four bits zero gives one bad-header word.
module bbc_run_header_parser
    import bbc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] run_kind, [3] fill_value, [19:4] fill_count, [23:20] tail_count,
    // [31:24] counter_count, [34:32] odd_position, [42:35] data_byte, rest 0
    output logic [47:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // [1:0] item_kind
    output logic        m_axis_tlast    // run_end
);

    logic   in_fire;
    logic   push;
    entry_t push_entry;
    logic   pop;
    entry_t head;
    logic   not_empty;
    logic   full;

    assign s_axis_tready = !full;
    assign in_fire       = s_axis_tvalid && !full;

    bbc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .in_byte    (s_axis_tdata),
        .push       (push),
        .push_entry (push_entry)
    );

    bbc_queue #(.DEPTH(DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .not_empty  (not_empty),
        .full       (full)
    );

    bbc_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .head_valid    (not_empty),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

### rtl/bbc_front.sv
// ----------------------------------------------------------------------------
// bbc_front
// Header, counter and tail parser: classifies each byte and queues results.
// ----------------------------------------------------------------------------
module bbc_front
    import bbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic [7:0] in_byte,
    output logic       push,
    output entry_t     push_entry
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  type_reg, type_next;
    logic        fill_reg, fill_next;
    logic [2:0]  odd_reg, odd_next;
    logic [3:0]  tlen_reg, tlen_next;
    logic [3:0]  tleft_reg, tleft_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  cnt_reg, cnt_next;

    logic        finish;
    logic        to_tail;
    logic        is_odd_type;
    logic [16:0] sum_wide;
    logic [1:0]  e_kind;
    logic [7:0]  e_data;
    logic        e_end;
    logic        e_pair;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            type_reg  <= RT_NONE;
            fill_reg  <= 1'b0;
            odd_reg   <= 3'd0;
            tlen_reg  <= 4'd0;
            tleft_reg <= 4'd0;
            sum_reg   <= 16'd0;
            cnt_reg   <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            fill_reg  <= fill_next;
            odd_reg   <= odd_next;
            tlen_reg  <= tlen_next;
            tleft_reg <= tleft_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign sum_wide    = {1'b0, sum_reg} + {10'd0, in_byte[6:0]};
    assign is_odd_type = (type_next == RT_FILL_ODD) || (type_next == RT_CNT_ODD);
    assign to_tail     = !is_odd_type && (tlen_next != 4'd0);

    // held fields and result
    always_comb
    begin
        type_next  = type_reg;
        fill_next  = fill_reg;
        odd_next   = odd_reg;
        tlen_next  = tlen_reg;
        tleft_next = tleft_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        finish     = 1'b0;
        push       = 1'b0;
        e_kind     = KIND_RUN;
        e_data     = 8'd0;
        e_end      = 1'b0;
        e_pair     = 1'b0;
        if (in_fire)
        begin
            case (phase_reg)
                PH_COUNTER:
                begin
                    sum_next = sum_wide[16] ? FILL_MAX : sum_wide[15:0];
                    cnt_next = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 8'd1;
                    finish   = !in_byte[7];
                end
                PH_TAIL:
                begin
                    tleft_next = tleft_reg - 4'd1;
                    push       = 1'b1;
                    e_kind     = KIND_TAIL;
                    e_data     = in_byte;
                    e_end      = (tleft_next == 4'd0);
                end
                default:
                begin
                    type_next  = RT_NONE;
                    fill_next  = 1'b0;
                    odd_next   = 3'd0;
                    tlen_next  = 4'd0;
                    tleft_next = 4'd0;
                    sum_next   = 16'd0;
                    cnt_next   = 8'd0;
                    if (in_byte[7])
                    begin
                        type_next = RT_FILL_TAIL;
                        fill_next = in_byte[6];
                        sum_next  = {14'd0, in_byte[5:4]};
                        tlen_next = in_byte[3:0];
                        finish    = 1'b1;
                    end
                    else if (in_byte[6])
                    begin
                        type_next = RT_FILL_ODD;
                        fill_next = in_byte[5];
                        sum_next  = {14'd0, in_byte[4:3]};
                        odd_next  = in_byte[2:0];
                        tlen_next = 4'd1;
                        finish    = 1'b1;
                    end
                    else if (in_byte[5])
                    begin
                        type_next = RT_CNT_TAIL;
                        fill_next = in_byte[4];
                        tlen_next = in_byte[3:0];
                    end
                    else if (in_byte[4])
                    begin
                        type_next = RT_CNT_ODD;
                        fill_next = in_byte[3];
                        odd_next  = in_byte[2:0];
                        tlen_next = 4'd1;
                    end
                    else
                    begin
                        push   = 1'b1;
                        e_kind = KIND_BAD;
                        e_end  = 1'b1;
                    end
                end
            endcase
            if (finish)
            begin
                push = 1'b1;
                if ((type_next == RT_FILL_ODD) || (type_next == RT_CNT_ODD))
                begin
                    e_pair = 1'b1;
                    e_data = fill_next ? ~(8'd1 << odd_next) : (8'd1 << odd_next);
                end
                else if (tlen_next == 4'd0)
                begin
                    e_end = 1'b1;
                end
                else
                begin
                    tleft_next = tlen_next;
                end
            end
        end
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (in_fire)
        begin
            case (phase_reg)
                PH_COUNTER:
                begin
                    if (!in_byte[7])
                        phase_next = to_tail ? PH_TAIL : PH_HEADER;
                end
                PH_TAIL:
                begin
                    if (tleft_reg == 4'd1)
                        phase_next = PH_HEADER;
                end
                default:
                begin
                    if (in_byte[7] || in_byte[6])
                        phase_next = to_tail ? PH_TAIL : PH_HEADER;
                    else if (in_byte[5] || in_byte[4])
                        phase_next = PH_COUNTER;
                    else
                        phase_next = PH_HEADER;
                end
            endcase
        end
    end

    always_comb
    begin
        push_entry.item_kind     = e_kind;
        push_entry.run_kind      = type_next;
        push_entry.fill_value    = fill_next;
        push_entry.fill_count    = sum_next;
        push_entry.tail_count    = tlen_next;
        push_entry.counter_count = cnt_next;
        push_entry.odd_position  = odd_next;
        push_entry.data_byte     = e_data;
        push_entry.run_end       = e_end;
        push_entry.pair          = e_pair;
    end

endmodule

### rtl/bbc_queue.sv
// ----------------------------------------------------------------------------
// bbc_queue
// Small first-in first-out queue of result entries between parser and output.
// ----------------------------------------------------------------------------
module bbc_queue
    import bbc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t head,
    output logic   not_empty,
    output logic   full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [AW-1:0] PTR_ONE  = AW'(1);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    entry_t        mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + PTR_ONE;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + PTR_ONE;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_ONE;
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_ONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

endmodule

### rtl/bbc_back.sv
// ----------------------------------------------------------------------------
// bbc_back
// Output stage: turns queue entries into result words, splitting pairs.
// ----------------------------------------------------------------------------
module bbc_back
    import bbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  entry_t      head,
    input  logic        head_valid,
    output logic        pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    logic        out_valid_reg, out_valid_next;
    logic        second_reg, second_next;
    logic [47:0] tdata_reg;
    logic [1:0]  tuser_reg;
    logic        tlast_reg;
    logic        load;
    logic [1:0]  sel_kind;
    logic [7:0]  sel_data;
    logic        sel_end;

    assign load = head_valid && (!out_valid_reg || m_axis_tready);
    assign pop  = load && (!head.pair || second_reg);

    always_comb
    begin
        sel_kind = head.item_kind;
        sel_data = head.data_byte;
        sel_end  = head.run_end;
        if (head.pair)
        begin
            if (second_reg)
            begin
                sel_kind = KIND_ODD;
                sel_end  = 1'b1;
            end
            else
            begin
                sel_kind = KIND_RUN;
                sel_data = 8'd0;
                sel_end  = 1'b0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        second_next    = second_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            second_next    = head.pair && !second_reg;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tdata_reg <= {5'd0, sel_data, head.odd_position, head.counter_count,
                          head.tail_count, head.fill_count, head.fill_value,
                          head.run_kind};
            tuser_reg <= sel_kind;
            tlast_reg <= sel_end;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tuser  = tuser_reg;
    assign m_axis_tlast  = tlast_reg;

endmodule

### tb/sv/bbc_run_header_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_run_header_parser_test
// Self-checking bench for the byte-aligned bitmap run header parser.
// ----------------------------------------------------------------------------
// Streams compressed bytes into the parser: a short directed opening, one
// long counter run that saturates both counts, then mostly well-formed runs
// with random content mixed with bad headers and stray bytes. A tracker
// decodes every accepted byte on its own and checks each output word, field
// by field, against the oldest word it expects. Both sides idle at random;
// the receiver also holds off once for a long stretch, and the sender
// pauses now and then until every expected word has drained.
// ----------------------------------------------------------------------------
package run_check_pkg;

    import bbc_pkg::*;

    typedef struct packed {
        kind_t       kind;
        logic [2:0]  run_kind;
        logic        fill_value;
        logic [15:0] fill_count;
        logic [3:0]  tail_count;
        logic [7:0]  counter_count;
        logic [2:0]  odd_position;
        logic [7:0]  data_byte;
        logic        run_end;
    } run_word_t;

    class run_word_tracker;

        phase_t      phase;
        logic [2:0]  held_type;
        logic        held_fill;
        logic [2:0]  held_odd;
        logic [3:0]  held_tail;
        logic [3:0]  tail_left;
        logic [15:0] fill_sum;
        logic [7:0]  counter_seen;
        run_word_t   pending_words[$];
        int          mismatches;
        int          bytes_taken;
        int          words_checked;
        int          runs_by_type[5];
        int          bad_headers;
        int          longest_count;

        function new();
            phase = PH_HEADER;
            clear_run();
        endfunction

        function void clear_run();
            held_type    = RT_NONE;
            held_fill    = 1'b0;
            held_odd     = 3'd0;
            held_tail    = 4'd0;
            tail_left    = 4'd0;
            fill_sum     = 16'd0;
            counter_seen = 8'd0;
        endfunction

        function int pending();
            return pending_words.size();
        endfunction

        function void queue_word(kind_t kind, logic [7:0] data, logic last);
            run_word_t w;
            w.kind          = kind;
            w.run_kind      = held_type;
            w.fill_value    = held_fill;
            w.fill_count    = fill_sum;
            w.tail_count    = held_tail;
            w.counter_count = counter_seen;
            w.odd_position  = held_odd;
            w.data_byte     = data;
            w.run_end       = last;
            pending_words.push_back(w);
        endfunction

        // run record, then the odd byte or the tail phase
        function void close_run();
            logic [7:0] one_hot;
            runs_by_type[held_type]++;
            if (counter_seen > longest_count)
                longest_count = counter_seen;
            if (held_type == RT_FILL_ODD || held_type == RT_CNT_ODD)
            begin
                one_hot = 8'd1 << held_odd;
                queue_word(KIND_RUN, 8'd0, 1'b0);
                queue_word(KIND_ODD, held_fill ? ~one_hot : one_hot, 1'b1);
                phase = PH_HEADER;
            end
            else if (held_tail == 4'd0)
            begin
                queue_word(KIND_RUN, 8'd0, 1'b1);
                phase = PH_HEADER;
            end
            else
            begin
                tail_left = held_tail;
                phase = PH_TAIL;
                queue_word(KIND_RUN, 8'd0, 1'b0);
            end
        endfunction

        function void take_byte(logic [7:0] b);
            int unsigned sum;
            bytes_taken++;
            case (phase)
                PH_COUNTER:
                begin
                    sum = fill_sum + b[6:0];
                    fill_sum = (sum > FILL_MAX) ? FILL_MAX : sum[15:0];
                    if (counter_seen != COUNT_MAX)
                        counter_seen++;
                    if (!b[7])
                        close_run();
                end
                PH_TAIL:
                begin
                    tail_left--;
                    queue_word(KIND_TAIL, b, tail_left == 4'd0);
                    if (tail_left == 4'd0)
                        phase = PH_HEADER;
                end
                default:
                begin
                    clear_run();
                    phase = PH_HEADER;
                    if (b[7])
                    begin
                        held_type = RT_FILL_TAIL;
                        held_fill = b[6];
                        fill_sum  = {14'd0, b[5:4]};
                        held_tail = b[3:0];
                        close_run();
                    end
                    else if (b[6])
                    begin
                        held_type = RT_FILL_ODD;
                        held_fill = b[5];
                        fill_sum  = {14'd0, b[4:3]};
                        held_odd  = b[2:0];
                        held_tail = 4'd1;
                        close_run();
                    end
                    else if (b[5])
                    begin
                        held_type = RT_CNT_TAIL;
                        held_fill = b[4];
                        held_tail = b[3:0];
                        phase = PH_COUNTER;
                    end
                    else if (b[4])
                    begin
                        held_type = RT_CNT_ODD;
                        held_fill = b[3];
                        held_odd  = b[2:0];
                        held_tail = 4'd1;
                        phase = PH_COUNTER;
                    end
                    else
                    begin
                        bad_headers++;
                        queue_word(KIND_BAD, 8'd0, 1'b1);
                    end
                end
            endcase
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_word(logic [1:0] kind, logic [47:0] data, logic last);
            run_word_t want;
            words_checked++;
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word: kind %0h data 0x%0h last %0b",
                         $time, kind, data, last);
                mismatches++;
                return;
            end
            want = pending_words.pop_front();
            compare_field("item_kind", want.kind, kind);
            compare_field("run_kind", want.run_kind, data[2:0]);
            compare_field("fill_value", want.fill_value, data[3]);
            compare_field("fill_count", want.fill_count, data[19:4]);
            compare_field("tail_count", want.tail_count, data[23:20]);
            compare_field("counter_count", want.counter_count, data[31:24]);
            compare_field("odd_position", want.odd_position, data[34:32]);
            compare_field("data_byte", want.data_byte, data[42:35]);
            compare_field("padding", 16'd0, data[47:43]);
            compare_field("run_end", want.run_end, last);
        endfunction

    endclass

endpackage

module bbc_run_header_parser_test;

    import bbc_pkg::*;
    import run_check_pkg::*;

    localparam int BYTE_TARGET = 1250;

    // bad headers, every run type at the field extremes, empty tails
    localparam logic [7:0] OPENING [19] = '{
        8'h00, 8'h0F,
        8'h80,
        8'hF2, 8'h00, 8'hFF,
        8'h40, 8'h7F,
        8'h20, 8'hFF, 8'h7F,
        8'h31, 8'h00, 8'hA5,
        8'h10, 8'h80, 8'h01,
        8'h1F, 8'h7F
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    run_word_tracker tracker = new();
    int send_gap_max = 12;
    int hold_off_cycles = 0;

    bbc_run_header_parser uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        tracker.take_byte(b);
    endtask

    // drop the offer first so the last byte is not taken twice
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    task automatic send_run();
        int pick;
        int n;
        logic [7:0] hdr;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            send_byte(8'($urandom_range(0, 255)));
        else if (pick < 16)
            send_byte(8'($urandom_range(0, 15)));
        else
        begin
            case ($urandom_range(1, 4))
                1:       hdr = 8'h80 | 8'($urandom_range(0, 127));
                2:       hdr = 8'h40 | 8'($urandom_range(0, 63));
                3:       hdr = 8'h20 | 8'($urandom_range(0, 31));
                default: hdr = 8'h10 | 8'($urandom_range(0, 15));
            endcase
            send_byte(hdr);
            // counter types: continuation bytes, then one with the top bit clear
            if (hdr[7:5] == 3'b001 || hdr[7:4] == 4'b0001)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
                repeat (n - 1) send_byte(8'h80 | 8'($urandom_range(0, 127)));
                send_byte(8'($urandom_range(0, 127)));
            end
            // tail types: copy exactly the tail length
            if (hdr[7] || hdr[7:5] == 3'b001)
                repeat (hdr[3:0]) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // receiver: random stalls per word, stretches without stalls, one long hold
    initial
    begin
        int stall;
        int stall_max;
        int mode_left;
        stall_max = 12;
        mode_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                stall = hold_off_cycles;
                hold_off_cycles = 0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
                    mode_left = $urandom_range(10, 40);
                end
                mode_left--;
                stall = $urandom_range(0, stall_max);
            end
            if (stall > 0)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (m_axis_tvalid !== 1'b1);
            tracker.check_word(m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end
    end

    initial
    begin
        int runs;
        runs = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (OPENING[i])
            send_byte(OPENING[i]);
        drain_results();

        // long counter run: drives both the fill sum and the counter count to saturation
        send_gap_max = 2;
        send_byte(8'h2F);
        repeat (520) send_byte(8'hFF);
        send_byte(8'h7F);
        repeat (15) send_byte(8'($urandom_range(0, 255)));

        while (tracker.bytes_taken < BYTE_TARGET)
        begin
            runs++;
            if (runs % 25 == 1)
                send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            if (runs == 40)
            begin
                // hold the output off while bytes keep coming, so the queue fills
                hold_off_cycles = 200;
                send_gap_max = 0;
            end
            if (runs == 90 || runs == 160)
                drain_results();
            send_run();
        end

        drain_results();
        repeat (20) @(posedge clk);
        $display("Sent %0d bytes, checked %0d result words, %0d bad headers.",
                 tracker.bytes_taken, tracker.words_checked, tracker.bad_headers);
        $display("Runs of type 1..4: %0d %0d %0d %0d; longest counter count %0d.",
                 tracker.runs_by_type[1], tracker.runs_by_type[2],
                 tracker.runs_by_type[3], tracker.runs_by_type[4], tracker.longest_count);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/bbc_pkg.sv
rtl/bbc_front.sv
rtl/bbc_queue.sv
rtl/bbc_back.sv
rtl/bbc_run_header_parser.sv
tb/sv/bbc_run_header_parser_test.sv
